### design/local_alignment_window_scorer_assert.svh
// Assertion macros used by the scorer's top module.
// Each macro expects signals named clock and reset in the module that uses it.
`ifndef LOCAL_ALIGNMENT_WINDOW_SCORER_ASSERT_SVH
`define LOCAL_ALIGNMENT_WINDOW_SCORER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define LAWS_ASSERT_IMPLIES(label, pre, post, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (pre) |-> (post)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define LAWS_ASSERT_NEXT(label, pre, post, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (pre) |=> (post)) \
      else $error(msg);

`endif

### design/lawsc_pkg.sv
package lawsc_pkg;

   // Command codes of the request channel.
   localparam logic [1:0] CMD_CLEAR  = 2'd0;
   localparam logic [1:0] CMD_APPEND = 2'd1;
   localparam logic [1:0] CMD_REF    = 2'd2;

   localparam int SYM_W = 8;

   // Control bits that travel with one reference column along the cell row.
   typedef struct packed {
      logic valid;    // a reference symbol occupies this stage
      logic compute;  // the column lies inside the window capacity
      logic first;    // first column of a window: stored scores read as zero
      logic wend;     // last symbol of the window, a result follows
      logic ovf;      // overflow flag as seen when the symbol was taken
   } token_ctrl_type;

endpackage

### design/local_alignment_window_scorer.sv
// Channel   Direction  Handshake              Payload
// req       in         req_valid / req_stall  command, symbol, window_end
// rsp       out        rsp_valid / rsp_stall  found, best_score, query_end, ref_end,
//                                             ref_start, overflow
//
// At most one reference symbol is taken per cycle, while req_stall is low; each
// moves down a row of QUERY_MAX cells, one cell per cycle while the row advances,
// and a window's result is registered in the tail once its last symbol leaves the row.
// A clear or append transaction waits until the cell row is empty: a drain counter,
// loaded by each reference symbol and counted down only while the row advances,
// must reach zero before the transaction is taken.
// Reset is synchronous and active high; no clearing pass follows it.
// While a result is held by rsp_stall, the whole cell row freezes and req_stall
// is raised.
`include "local_alignment_window_scorer_assert.svh"

module local_alignment_window_scorer
   import lawsc_pkg::*;
#(
   parameter int QUERY_MAX  = 256,
   parameter int WINDOW_MAX = 1024
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_command,
   input  logic [7:0]  req_symbol,
   input  logic        req_window_end,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_found,
   output logic [8:0]  rsp_best_score,
   output logic [8:0]  rsp_query_end,
   output logic [10:0] rsp_ref_end,
   output logic [9:0]  rsp_ref_start,
   output logic        rsp_overflow
);

   // Score, row and query length widths follow the query capacity; column and
   // origin widths follow the window capacity.
   localparam int SW = $clog2(QUERY_MAX + 1);
   localparam int CW = $clog2(WINDOW_MAX + 1);
   localparam int DW = $clog2(QUERY_MAX + 2);

   logic [SW-1:0] query_count_ff, query_count_in;
   logic [CW-1:0] col_idx_ff, col_idx_in;
   logic          overflow_ff, overflow_in;
   logic [DW-1:0] drain_ff, drain_in;

   logic          advance;
   logic          wait_drain;
   logic          accept;
   logic          ref_take;
   logic          col_room;
   logic          append_write;

   logic [QUERY_MAX-1:0] cell_active;
   logic [QUERY_MAX-1:0] cell_load;

   // Links between neighboring cells; link 0 is fed from the request side.
   token_ctrl_type   ctrl_link       [0:QUERY_MAX];
   logic [SYM_W-1:0] sym_link        [0:QUERY_MAX];
   logic [CW-1:0]    col_link        [0:QUERY_MAX];
   logic [SW-1:0]    up_s_link       [0:QUERY_MAX];
   logic [CW-1:0]    up_o_link       [0:QUERY_MAX];
   logic [SW-1:0]    diag_s_link     [0:QUERY_MAX];
   logic [CW-1:0]    diag_o_link     [0:QUERY_MAX];
   logic [SW-1:0]    best_s_link     [0:QUERY_MAX];
   logic [SW-1:0]    best_row_link   [0:QUERY_MAX];
   logic [CW-1:0]    best_col_link   [0:QUERY_MAX];
   logic [CW-1:0]    best_start_link [0:QUERY_MAX];

   // The row moves whenever the output register can take a result.
   assign advance    = !rsp_valid || !rsp_stall;
   // Query changes must not disturb columns still moving through the row.
   assign wait_drain = req_valid && (drain_ff != '0) &&
                       ((req_command == CMD_CLEAR) || (req_command == CMD_APPEND));
   assign req_stall  = !advance || wait_drain;
   assign accept     = req_valid && !req_stall;
   assign ref_take   = accept && (req_command == CMD_REF);
   assign col_room   = (col_idx_ff < CW'(WINDOW_MAX));
   assign append_write = accept && (req_command == CMD_APPEND) &&
                         (query_count_ff < SW'(QUERY_MAX));

   always_comb begin
      query_count_in = query_count_ff;
      col_idx_in     = col_idx_ff;
      overflow_in    = overflow_ff;
      drain_in       = drain_ff;
      if (advance && (drain_ff != '0)) begin
         drain_in = DW'(drain_ff - 1'b1);
      end
      if (accept) begin
         case (req_command)
            CMD_CLEAR: begin
               query_count_in = '0;
               overflow_in    = 1'b0;
               col_idx_in     = '0;
            end
            CMD_APPEND: begin
               if (query_count_ff < SW'(QUERY_MAX)) begin
                  query_count_in = SW'(query_count_ff + 1'b1);
               end else begin
                  overflow_in = 1'b1;
               end
               col_idx_in = '0;
            end
            CMD_REF: begin
               drain_in = DW'(QUERY_MAX + 1);
               if (col_room) begin
                  col_idx_in = CW'(col_idx_ff + 1'b1);
               end else begin
                  overflow_in = 1'b1;
               end
               if (req_window_end) begin
                  col_idx_in = '0;
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         query_count_ff <= '0;
         col_idx_ff     <= '0;
         overflow_ff    <= 1'b0;
         drain_ff       <= '0;
      end else begin
         query_count_ff <= query_count_in;
         col_idx_ff     <= col_idx_in;
         overflow_ff    <= overflow_in;
         drain_ff       <= drain_in;
      end
   end

   // Column entering the row. Row zero scores zero and stops at its own column;
   // its previous column also scores zero, with origin one column back.
   always_comb begin
      ctrl_link[0].valid   = ref_take;
      ctrl_link[0].compute = col_room;
      ctrl_link[0].first   = (col_idx_ff == '0);
      ctrl_link[0].wend    = req_window_end;
      ctrl_link[0].ovf     = overflow_ff || !col_room;
      sym_link[0]          = req_symbol;
      col_link[0]          = CW'(col_idx_ff + 1'b1);
      up_s_link[0]         = '0;
      up_o_link[0]         = CW'(col_idx_ff + 1'b1);
      diag_s_link[0]       = '0;
      diag_o_link[0]       = col_idx_ff;
      best_s_link[0]       = '0;
      best_row_link[0]     = '0;
      best_col_link[0]     = '0;
      best_start_link[0]   = '0;
   end

   // One cell per query row; cell k holds query symbol k and row k + 1 of the
   // previous column.
   for (genvar k = 0; k < QUERY_MAX; k++) begin : g_cell
      assign cell_active[k] = (query_count_ff > SW'(k));
      assign cell_load[k]   = append_write && (query_count_ff == SW'(k));

      lawsc_cell #(
         .SW (SW),
         .CW (CW),
         .ROW(k + 1)
      ) u_cell (
         .clock         (clock),
         .reset         (reset),
         .advance       (advance),
         .active        (cell_active[k]),
         .load_en       (cell_load[k]),
         .load_symbol   (req_symbol),
         .in_ctrl       (ctrl_link[k]),
         .in_sym        (sym_link[k]),
         .in_col        (col_link[k]),
         .in_up_s       (up_s_link[k]),
         .in_up_o       (up_o_link[k]),
         .in_diag_s     (diag_s_link[k]),
         .in_diag_o     (diag_o_link[k]),
         .in_best_s     (best_s_link[k]),
         .in_best_row   (best_row_link[k]),
         .in_best_col   (best_col_link[k]),
         .in_best_start (best_start_link[k]),
         .out_ctrl      (ctrl_link[k+1]),
         .out_sym       (sym_link[k+1]),
         .out_col       (col_link[k+1]),
         .out_up_s      (up_s_link[k+1]),
         .out_up_o      (up_o_link[k+1]),
         .out_diag_s    (diag_s_link[k+1]),
         .out_diag_o    (diag_o_link[k+1]),
         .out_best_s    (best_s_link[k+1]),
         .out_best_row  (best_row_link[k+1]),
         .out_best_col  (best_col_link[k+1]),
         .out_best_start(best_start_link[k+1])
      );
   end

   // The tail folds each column's best cell into the window's best and
   // registers the result transaction.
   lawsc_tail #(
      .SW(SW),
      .CW(CW)
   ) u_tail (
      .clock         (clock),
      .reset         (reset),
      .advance       (advance),
      .in_ctrl       (ctrl_link[QUERY_MAX]),
      .in_best_s     (best_s_link[QUERY_MAX]),
      .in_best_row   (best_row_link[QUERY_MAX]),
      .in_best_col   (best_col_link[QUERY_MAX]),
      .in_best_start (best_start_link[QUERY_MAX]),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_found     (rsp_found),
      .rsp_best_score(rsp_best_score),
      .rsp_query_end (rsp_query_end),
      .rsp_ref_end   (rsp_ref_end),
      .rsp_ref_start (rsp_ref_start),
      .rsp_overflow  (rsp_overflow)
   );

   `LAWS_ASSERT_IMPLIES(a_query_change_on_empty_row,
      accept && ((req_command == CMD_CLEAR) || (req_command == CMD_APPEND)),
      drain_ff == '0, "query changed while columns were in flight")

   `LAWS_ASSERT_NEXT(a_window_end_restarts_columns,
      ref_take && req_window_end, col_idx_ff == '0,
      "column index not restarted after the end of a window")

   `LAWS_ASSERT_NEXT(a_overflow_sticky,
      overflow_ff && !(accept && (req_command == CMD_CLEAR)), overflow_ff,
      "overflow flag dropped without a clear")

   `LAWS_ASSERT_IMPLIES(a_column_index_bound, 1'b1, col_idx_ff <= CW'(WINDOW_MAX),
      "column index beyond the window capacity")

endmodule

### design/lawsc_cell.sv
module lawsc_cell
   import lawsc_pkg::*;
#(
   parameter int SW  = 9,
   parameter int CW  = 11,
   parameter int ROW = 1
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 advance,
   input  logic                 active,
   input  logic                 load_en,
   input  logic [SYM_W-1:0]     load_symbol,
   input  token_ctrl_type       in_ctrl,
   input  logic [SYM_W-1:0]     in_sym,
   input  logic [CW-1:0]        in_col,
   input  logic [SW-1:0]        in_up_s,
   input  logic [CW-1:0]        in_up_o,
   input  logic [SW-1:0]        in_diag_s,
   input  logic [CW-1:0]        in_diag_o,
   input  logic [SW-1:0]        in_best_s,
   input  logic [SW-1:0]        in_best_row,
   input  logic [CW-1:0]        in_best_col,
   input  logic [CW-1:0]        in_best_start,
   output token_ctrl_type       out_ctrl,
   output logic [SYM_W-1:0]     out_sym,
   output logic [CW-1:0]        out_col,
   output logic [SW-1:0]        out_up_s,
   output logic [CW-1:0]        out_up_o,
   output logic [SW-1:0]        out_diag_s,
   output logic [CW-1:0]        out_diag_o,
   output logic [SW-1:0]        out_best_s,
   output logic [SW-1:0]        out_best_row,
   output logic [CW-1:0]        out_best_col,
   output logic [CW-1:0]        out_best_start
);

   localparam logic [SW-1:0] ROW_ID = SW'(ROW);

   logic [SYM_W-1:0] query_sym_ff;
   logic [SW-1:0]    left_s_ff;
   logic [CW-1:0]    left_o_ff;

   token_ctrl_type   ctrl_ff;
   logic [SYM_W-1:0] sym_ff;
   logic [CW-1:0]    col_ff;
   logic [SW-1:0]    up_s_ff, up_s_in;
   logic [CW-1:0]    up_o_ff, up_o_in;
   logic [SW-1:0]    diag_s_ff, diag_s_in;
   logic [CW-1:0]    diag_o_ff, diag_o_in;
   logic [SW-1:0]    best_s_ff, best_s_in;
   logic [SW-1:0]    best_row_ff, best_row_in;
   logic [CW-1:0]    best_col_ff, best_col_in;
   logic [CW-1:0]    best_start_ff, best_start_in;

   logic            work;
   logic [SW-1:0]   left_s;
   logic [CW-1:0]   left_o;
   logic [SW-1:0]   d_s, u_s, l_s, v_s;
   logic [CW-1:0]   v_o;

   always_comb begin
      work   = in_ctrl.valid && in_ctrl.compute && active;
      // A new window sees an all-zero previous column.
      left_s = in_ctrl.first ? '0 : left_s_ff;
      left_o = in_ctrl.first ? '0 : left_o_ff;

      d_s = in_diag_s + SW'(query_sym_ff == in_sym);
      u_s = (in_up_s == '0) ? '0 : in_up_s - 1'b1;
      l_s = (left_s == '0) ? '0 : left_s - 1'b1;

      v_s = d_s;
      if (u_s > v_s) begin
         v_s = u_s;
      end
      if (l_s > v_s) begin
         v_s = l_s;
      end

      // A zero score starts at its own column; otherwise the traceback origin has priority diagonal, up, then left.
      if (v_s == '0) begin
         v_o = in_col;
      end else if (v_s == d_s) begin
         v_o = in_diag_o;
      end else if (v_s == u_s) begin
         v_o = in_up_o;
      end else begin
         v_o = left_o;
      end

      up_s_in       = in_up_s;
      up_o_in       = in_up_o;
      diag_s_in     = in_diag_s;
      diag_o_in     = in_diag_o;
      best_s_in     = in_best_s;
      best_row_in   = in_best_row;
      best_col_in   = in_best_col;
      best_start_in = in_best_start;
      if (work) begin
         up_s_in   = v_s;
         up_o_in   = v_o;
         diag_s_in = left_s;
         diag_o_in = left_o;
         // Lower rows arrive first, so only a strictly higher score wins.
         if (v_s > in_best_s) begin
            best_s_in     = v_s;
            best_row_in   = ROW_ID;
            best_col_in   = in_col;
            best_start_in = v_o;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctrl_ff <= '0;
      end else if (advance) begin
         ctrl_ff <= in_ctrl;
      end
   end

   always_ff @(posedge clock) begin
      if (load_en) begin
         query_sym_ff <= load_symbol;
      end
      if (advance) begin
         sym_ff        <= in_sym;
         col_ff        <= in_col;
         up_s_ff       <= up_s_in;
         up_o_ff       <= up_o_in;
         diag_s_ff     <= diag_s_in;
         diag_o_ff     <= diag_o_in;
         best_s_ff     <= best_s_in;
         best_row_ff   <= best_row_in;
         best_col_ff   <= best_col_in;
         best_start_ff <= best_start_in;
         if (work) begin
            left_s_ff <= v_s;
            left_o_ff <= v_o;
         end
      end
   end

   assign out_ctrl       = ctrl_ff;
   assign out_sym        = sym_ff;
   assign out_col        = col_ff;
   assign out_up_s       = up_s_ff;
   assign out_up_o       = up_o_ff;
   assign out_diag_s     = diag_s_ff;
   assign out_diag_o     = diag_o_ff;
   assign out_best_s     = best_s_ff;
   assign out_best_row   = best_row_ff;
   assign out_best_col   = best_col_ff;
   assign out_best_start = best_start_ff;

endmodule

### design/lawsc_tail.sv
module lawsc_tail
   import lawsc_pkg::*;
#(
   parameter int SW = 9,
   parameter int CW = 11
) (
   input  logic           clock,
   input  logic           reset,
   input  logic           advance,
   input  token_ctrl_type in_ctrl,
   input  logic [SW-1:0]  in_best_s,
   input  logic [SW-1:0]  in_best_row,
   input  logic [CW-1:0]  in_best_col,
   input  logic [CW-1:0]  in_best_start,
   output logic           rsp_valid,
   input  logic           rsp_stall,
   output logic           rsp_found,
   output logic [8:0]     rsp_best_score,
   output logic [8:0]     rsp_query_end,
   output logic [10:0]    rsp_ref_end,
   output logic [9:0]     rsp_ref_start,
   output logic           rsp_overflow
);

   logic [SW-1:0] trk_s_ff, trk_s_in;
   logic [SW-1:0] trk_row_ff, trk_row_in;
   logic [CW-1:0] trk_col_ff, trk_col_in;
   logic [CW-1:0] trk_start_ff, trk_start_in;

   logic          rsp_valid_ff;
   logic          found_ff;
   logic [8:0]    score_ff;
   logic [8:0]    query_end_ff;
   logic [10:0]   ref_end_ff;
   logic [9:0]    ref_start_ff;
   logic          overflow_ff;

   logic          take;
   logic          found_in;

   always_comb begin
      trk_s_in     = in_ctrl.first ? '0 : trk_s_ff;
      trk_row_in   = in_ctrl.first ? '0 : trk_row_ff;
      trk_col_in   = in_ctrl.first ? '0 : trk_col_ff;
      trk_start_in = in_ctrl.first ? '0 : trk_start_ff;
      // Earlier columns win ties unless the new cell sits in a lower row.
      if ((in_best_s > trk_s_in) ||
          ((in_best_s != '0) && (in_best_s == trk_s_in) && (in_best_row < trk_row_in))) begin
         trk_s_in     = in_best_s;
         trk_row_in   = in_best_row;
         trk_col_in   = in_best_col;
         trk_start_in = in_best_start;
      end
      take     = advance && in_ctrl.valid;
      found_in = (trk_s_in != '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (take && in_ctrl.wend) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         trk_s_ff     <= trk_s_in;
         trk_row_ff   <= trk_row_in;
         trk_col_ff   <= trk_col_in;
         trk_start_ff <= trk_start_in;
         if (in_ctrl.wend) begin
            found_ff     <= found_in;
            score_ff     <= 9'(trk_s_in);
            query_end_ff <= found_in ? 9'(trk_row_in) : '0;
            ref_end_ff   <= found_in ? 11'(trk_col_in) : '0;
            ref_start_ff <= found_in ? 10'(trk_start_in) : '0;
            overflow_ff  <= in_ctrl.ovf;
         end
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_found      = found_ff;
   assign rsp_best_score = score_ff;
   assign rsp_query_end  = query_end_ff;
   assign rsp_ref_end    = ref_end_ff;
   assign rsp_ref_start  = ref_start_ff;
   assign rsp_overflow   = overflow_ff;

endmodule

### tb/local_alignment_window_scorer_test.sv
`timescale 1ns / 1ps

module local_alignment_window_scorer_test;
   import lawsc_pkg::*;

   localparam int QUERY_MAX  = 256;
   localparam int WINDOW_MAX = 1024;

   // Command code 3 has no meaning in the block; it must be ignored.
   localparam logic [1:0] CMD_UNUSED = 2'd3;

   // A result passes the whole cell row and the tail register after the transaction that
   // ends its window, so the drain after the last expected result is longer than the
   // row, to catch a stray result.
   localparam int DRAIN_CYCLES  = QUERY_MAX + 64;
   localparam int CYCLE_LIMIT   = 600000;
   localparam int HOLD_CYCLES   = 1000;
   localparam int PHASE_ITEMS   = 60;

   // One transaction of the request channel.
   typedef struct {
      logic [1:0] command;
      logic [7:0] symbol;
      logic       window_end;
   } seq_op_type;

   // One alignment report as the block should deliver it.
   typedef struct {
      logic        found;
      logic [8:0]  score;
      logic [8:0]  qry_end;
      logic [10:0] ref_end;
      logic [9:0]  ref_start;
      logic        ovf;
   } hit_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [1:0]  req_command = CMD_CLEAR;
   logic [7:0]  req_symbol = 8'h00;
   logic        req_window_end = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic        rsp_found;
   logic [8:0]  rsp_best_score;
   logic [8:0]  rsp_query_end;
   logic [10:0] rsp_ref_end;
   logic [9:0]  rsp_ref_start;
   logic        rsp_overflow;

   // Transactions waiting to be offered, and the reports that the accepted ones
   // are due to produce, oldest first.
   seq_op_type op_backlog[$];
   hit_type    hits_due[$];

   // Flow control knobs, changed between phases by the stimulus process (hold_off by the hold-off process).
   int  send_idle_pct = 0;
   int  recv_stall_pct = 0;
   logic hold_off = 1'b0;
   logic squeeze_go = 1'b0;

   logic req_taken = 1'b0;
   int   mismatches = 0;
   int   planned_ops = 0;
   int   cycle_count = 0;

   // Scoring state kept alongside the block: the loaded query, the last DP
   // column with the traceback origin of every cell, and the best cell so far.
   logic [7:0]  qry_sym [QUERY_MAX];
   int          qry_len = 0;
   int          col_score [QUERY_MAX + 1];
   int          col_origin [QUERY_MAX + 1];
   int          col_count = 0;
   int          best_val = 0;
   int          best_row = 0;
   int          best_col = 0;
   int          best_start = 0;
   logic        ovf_seen = 1'b0;

   local_alignment_window_scorer #(
      .QUERY_MAX (QUERY_MAX),
      .WINDOW_MAX(WINDOW_MAX)
   ) u_dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_command   (req_command),
      .req_symbol    (req_symbol),
      .req_window_end(req_window_end),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_found     (rsp_found),
      .rsp_best_score(rsp_best_score),
      .rsp_query_end (rsp_query_end),
      .rsp_ref_end   (rsp_ref_end),
      .rsp_ref_start (rsp_ref_start),
      .rsp_overflow  (rsp_overflow)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // ------------------------------------------------------------------------
   // Alignment scoring, kept in step with every accepted transaction.
   // ------------------------------------------------------------------------

   // A new window starts from an all-zero column and no best cell.
   function automatic void clear_window_state();
      for (int r = 0; r <= QUERY_MAX; r++) begin
         col_score[r] = 0;
         col_origin[r] = 0;
      end
      best_val = 0;
      best_row = 0;
      best_col = 0;
      best_start = 0;
      col_count = 0;
   endfunction

   // Computes one DP column for reference symbol sym at one-based column col.
   // The column is updated in place: before a row is overwritten its old value
   // is the left neighbor, and the old value of the row above is the diagonal.
   function automatic void score_column(logic [7:0] sym, int col);
      int up_s, up_o, diag_s, diag_o, left_s, left_o;
      int d, u, l, v, o;
      up_s = 0;
      up_o = col;
      diag_s = col_score[0];
      diag_o = col_origin[0];
      col_score[0] = 0;
      col_origin[0] = col;
      for (int r = 1; r <= qry_len; r++) begin
         left_s = col_score[r];
         left_o = col_origin[r];
         d = diag_s + ((qry_sym[r - 1] == sym) ? 1 : 0);
         u = up_s - 1;
         l = left_s - 1;
         v = 0;
         if (d > v) v = d;
         if (u > v) v = u;
         if (l > v) v = l;
         // A zero cell ends the traceback in its own column; otherwise the
         // origin is inherited with diagonal first, then up, then left.
         if (v <= 0) begin
            v = 0;
            o = col;
         end else if (v == d) begin
            o = diag_o;
         end else if (v == u) begin
            o = up_o;
         end else begin
            o = left_o;
         end
         col_score[r] = v;
         col_origin[r] = o;
         // The first maximum in row-major order wins. Columns arrive in
         // order, so within a later column only a lower row may replace an
         // equal score.
         if (v > best_val || (v > 0 && v == best_val && r < best_row)) begin
            best_val = v;
            best_row = r;
            best_col = col;
            best_start = o;
         end
         diag_s = left_s;
         diag_o = left_o;
         up_s = v;
         up_o = o;
      end
   endfunction

   // Applies one accepted transaction and queues the report that it causes.
   function automatic void align_step(logic [1:0] cmd, logic [7:0] sym, logic wend);
      hit_type hit;
      case (cmd)
         CMD_CLEAR: begin
            qry_len = 0;
            ovf_seen = 1'b0;
            clear_window_state();
         end
         CMD_APPEND: begin
            // Appends beyond capacity are dropped but flagged until a clear.
            if (qry_len < QUERY_MAX) begin
               qry_sym[qry_len] = sym;
               qry_len++;
            end else begin
               ovf_seen = 1'b1;
            end
            clear_window_state();
         end
         CMD_REF: begin
            if (col_count == 0) clear_window_state();
            // Symbols past the window capacity compute nothing, but a
            // window end on one of them still reports.
            if (col_count < WINDOW_MAX) begin
               col_count++;
               score_column(sym, col_count);
            end else begin
               ovf_seen = 1'b1;
            end
            if (wend) begin
               hit.found = (best_val > 0);
               hit.score = best_val[8:0];
               hit.qry_end = hit.found ? best_row[8:0] : 9'd0;
               hit.ref_end = hit.found ? best_col[10:0] : 11'd0;
               hit.ref_start = hit.found ? best_start[9:0] : 10'd0;
               hit.ovf = ovf_seen;
               hits_due.push_back(hit);
               clear_window_state();
            end
         end
         default: begin
         end
      endcase
   endfunction

   // ------------------------------------------------------------------------
   // Request driver: payload changes only at the falling edge, and a new
   // transaction is offered once the previous one was taken at the rising edge.
   // ------------------------------------------------------------------------
   always @(negedge clock) begin : driver
      seq_op_type nxt;
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_taken) begin
         if (op_backlog.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
            nxt = op_backlog.pop_front();
            req_valid <= 1'b1;
            req_command <= nxt.command;
            req_symbol <= nxt.symbol;
            req_window_end <= nxt.window_end;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Response stall: random per cycle, or held high during the long hold-off.
   always @(negedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         rsp_stall <= hold_off || ($urandom_range(0, 99) < recv_stall_pct);
      end
   end

   // The long hold-off counts its own cycles, so the sender keeps offering
   // while the result path is blocked and the cell row backs up.
   initial begin
      wait (squeeze_go);
      @(negedge clock);
      hold_off <= 1'b1;
      repeat (HOLD_CYCLES) @(negedge clock);
      hold_off <= 1'b0;
   end

   task automatic check_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
         mismatches++;
         $error("%s: expected %0d, got %0d", name, want, got);
      end
   endtask

   // ------------------------------------------------------------------------
   // Monitor: everything is sampled at the rising edge, where both channels
   // complete their transactions.
   // ------------------------------------------------------------------------
   always @(posedge clock) begin : monitor
      hit_type want;
      if (reset) begin
         req_taken <= 1'b0;
      end else begin
         req_taken <= req_valid && !req_stall;
         if (rsp_valid && !rsp_stall) begin
            if (hits_due.size() == 0) begin
               mismatches++;
               $error("result with no report pending: score %0d", rsp_best_score);
            end else begin
               want = hits_due.pop_front();
               check_field("found", 32'(want.found), 32'(rsp_found));
               check_field("best_score", 32'(want.score), 32'(rsp_best_score));
               check_field("query_end", 32'(want.qry_end), 32'(rsp_query_end));
               check_field("ref_end", 32'(want.ref_end), 32'(rsp_ref_end));
               check_field("ref_start", 32'(want.ref_start), 32'(rsp_ref_start));
               check_field("overflow", 32'(want.ovf), 32'(rsp_overflow));
            end
         end
         if (req_valid && !req_stall) begin
            align_step(req_command, req_symbol, req_window_end);
         end
      end
   end

   // Watchdog for a hung handshake or a missing result.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("FAIL local_alignment_window_scorer");
         $finish;
      end
   end

   // ------------------------------------------------------------------------
   // Stimulus.
   // ------------------------------------------------------------------------
   task automatic push_op(logic [1:0] cmd, logic [7:0] sym, logic wend);
      seq_op_type op;
      op.command = cmd;
      op.symbol = sym;
      op.window_end = wend;
      op_backlog.push_back(op);
      planned_ops++;
   endtask

   // One query load followed by a few windows. Symbols come from a four-letter
   // alphabet of random bytes, and window content mostly follows the query with
   // occasional insertions and deletions, so that real alignments form. A few
   // transactions are noise: unused commands, stray window ends, queries
   // changed in the middle of a window, and windows left without an end.
   task automatic plan_session();
      logic [7:0] alpha [4];
      logic [7:0] motif [$];
      logic [7:0] s;
      int qlen, nwin, wlen, pos, r, k, w;
      for (k = 0; k < 4; k++) alpha[k] = 8'($urandom_range(0, 255));
      if ($urandom_range(0, 9) != 0) begin
         push_op(CMD_CLEAR, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
      end
      r = $urandom_range(0, 99);
      if (r < 4) qlen = 0;
      else if (r < 90) qlen = $urandom_range(1, 12);
      else qlen = $urandom_range(13, 48);
      for (k = 0; k < qlen; k++) begin
         s = alpha[$urandom_range(0, 3)];
         motif.push_back(s);
         push_op(CMD_APPEND, s, 1'($urandom_range(0, 1)));
      end
      nwin = $urandom_range(1, 4);
      for (w = 0; w < nwin; w++) begin
         wlen = $urandom_range(1, 16);
         pos = (motif.size() != 0) ? $urandom_range(0, motif.size() - 1) : 0;
         for (k = 0; k < wlen; k++) begin
            r = $urandom_range(0, 99);
            if (r < 3) begin
               push_op(CMD_UNUSED, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
            end else if (r < 5 && k > 0) begin
               push_op(CMD_APPEND, alpha[$urandom_range(0, 3)], 1'($urandom_range(0, 1)));
            end
            if (pos < motif.size() && $urandom_range(0, 2) != 0) s = motif[pos];
            else s = alpha[$urandom_range(0, 3)];
            r = $urandom_range(0, 9);
            if (r == 1) pos += 2;
            else if (r != 0) pos += 1;
            push_op(CMD_REF, s, (k == wlen - 1) && ($urandom_range(0, 19) != 0));
         end
      end
   endtask

   initial begin : stimulus
      logic [7:0] nuc [4] = '{8'h41, 8'h43, 8'h47, 8'h54};
      logic [7:0] motif [$];
      logic [7:0] s;
      int k, phase_start;

      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Phase with no idling on either side.
      // A window against the empty query: columns count, nothing is found.
      push_op(CMD_REF, 8'h00, 1'b1);
      // The unused command and window ends on non-reference commands do nothing.
      push_op(CMD_UNUSED, 8'hFF, 1'b1);
      push_op(CMD_CLEAR, 8'hFF, 1'b1);
      push_op(CMD_APPEND, 8'h00, 1'b0);
      push_op(CMD_APPEND, 8'hFF, 1'b1);
      push_op(CMD_APPEND, 8'hA5, 1'b0);
      push_op(CMD_APPEND, 8'h5A, 1'b0);
      // Exact match of the query's tail.
      push_op(CMD_REF, 8'hFF, 1'b0);
      push_op(CMD_REF, 8'hA5, 1'b0);
      push_op(CMD_REF, 8'h5A, 1'b1);
      // Repeated symbols and an unused command in the middle of a window.
      push_op(CMD_REF, 8'h00, 1'b0);
      push_op(CMD_REF, 8'h00, 1'b0);
      push_op(CMD_UNUSED, 8'h00, 1'b0);
      push_op(CMD_REF, 8'hFF, 1'b1);
      // A lone mismatch scores nothing.
      push_op(CMD_REF, 8'h13, 1'b1);
      // An append abandons the open window; the next symbol starts a new one.
      push_op(CMD_REF, 8'h00, 1'b0);
      push_op(CMD_APPEND, 8'h00, 1'b1);
      push_op(CMD_REF, 8'h00, 1'b0);
      push_op(CMD_REF, 8'hFF, 1'b1);

      // Query and window both past capacity. The overflow flag then sticks
      // through a later window until a clear removes it.
      push_op(CMD_CLEAR, 8'h00, 1'b0);
      for (k = 0; k < QUERY_MAX + 4; k++) begin
         s = nuc[$urandom_range(0, 3)];
         motif.push_back(s);
         push_op(CMD_APPEND, s, 1'b0);
      end
      for (k = 0; k < WINDOW_MAX + 3; k++) begin
         if ($urandom_range(0, 9) < 7) s = motif[k % QUERY_MAX];
         else s = nuc[$urandom_range(0, 3)];
         push_op(CMD_REF, s, k == WINDOW_MAX + 2);
      end
      push_op(CMD_REF, motif[0], 1'b0);
      push_op(CMD_REF, motif[1], 1'b0);
      push_op(CMD_REF, motif[2], 1'b1);
      push_op(CMD_CLEAR, 8'h00, 1'b0);
      push_op(CMD_APPEND, nuc[0], 1'b0);
      push_op(CMD_APPEND, nuc[1], 1'b0);
      push_op(CMD_REF, nuc[0], 1'b0);
      push_op(CMD_REF, nuc[1], 1'b1);

      // Load a short query, then hold off the result side while windows keep
      // coming, so that a result blocks the row and the request side stalls.
      push_op(CMD_CLEAR, 8'h00, 1'b0);
      for (k = 0; k < 6; k++) push_op(CMD_APPEND, nuc[k % 4], 1'b0);
      while (op_backlog.size() != 0) @(posedge clock);
      squeeze_go = 1'b1;
      for (k = 0; k < 60; k++) push_op(CMD_REF, nuc[$urandom_range(0, 3)], (k % 5) == 4);

      phase_start = planned_ops;
      while (planned_ops - phase_start < PHASE_ITEMS) plan_session();
      while (op_backlog.size() != 0) @(posedge clock);

      // Sender mostly idle.
      send_idle_pct = 79;
      recv_stall_pct = 0;
      phase_start = planned_ops;
      while (planned_ops - phase_start < PHASE_ITEMS) plan_session();
      while (op_backlog.size() != 0) @(posedge clock);

      // Receiver mostly stalling.
      send_idle_pct = 0;
      recv_stall_pct = 79;
      phase_start = planned_ops;
      while (planned_ops - phase_start < PHASE_ITEMS) plan_session();
      while (op_backlog.size() != 0) @(posedge clock);

      // Both sides idling now and then.
      send_idle_pct = 25;
      recv_stall_pct = 25;
      phase_start = planned_ops;
      while (planned_ops - phase_start < PHASE_ITEMS) plan_session();

      while (op_backlog.size() != 0 || req_valid) @(posedge clock);
      while (hits_due.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0) begin
         $display("PASS local_alignment_window_scorer");
      end else begin
         $display("FAIL local_alignment_window_scorer");
      end
      $finish;
   end

endmodule

### sim.f
+incdir+design
design/lawsc_pkg.sv
design/lawsc_cell.sv
design/lawsc_tail.sv
design/local_alignment_window_scorer.sv
tb/local_alignment_window_scorer_test.sv
